// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an asynchronous active-low reset that disables it.
`define FGT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FGT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`FGT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define FGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`FGT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/fgt_pkg.sv =====
package fgt_pkg;

	localparam int MAX_FRAGMENTS_DEF = 4096;
	localparam int MAX_WINDOW_DEF    = 64;
	localparam int RESULT_CAP        = 32;
	localparam int FIELD_W           = 12;
	localparam logic [6:0] WINDOW_SIZE_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_START    = 2'd0,
		OP_FRAGMENT = 2'd1,
		OP_STATUS   = 2'd2,
		OP_RESERVED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACCEPTED     = 3'd0,
		KIND_DUPLICATE    = 3'd1,
		KIND_OUT_OF_RANGE = 3'd2,
		KIND_MISSING      = 3'd3,
		KIND_ADVANCED     = 3'd4,
		KIND_COMPLETE     = 3'd5,
		KIND_STARTED      = 3'd6,
		KIND_IDLE         = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FRAG,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

// ===== rtl/core/fragment_gap_tracker.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, fragment_index, fragment_total
// out      out_valid / out_ready kind, range_start, range_end, last
// cfg      cfg_valid / cfg_ready window_size
//
// A fragment beat takes map read, update, hand-off; an idle result only hand-off.
// A start beat sweeps the map clear up to its total (capped at MAX_FRAGMENTS),
// one entry a cycle through the single write port, before the next beat is taken.
// A status tick on an active transfer scans the window, one map read a cycle
// unless the scan pauses while a missing-range result waits on a stalled output.
// Reset clears control state and sets window_size to 64; the map needs no
// clearing after reset since no entry is read before a start beat has swept it.
module fragment_gap_tracker #(
	parameter int MAX_FRAGMENTS = fgt_pkg::MAX_FRAGMENTS_DEF,
	parameter int MAX_WINDOW    = fgt_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [11:0] fragment_index,
	input  logic [12:0] fragment_total,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [11:0] range_start,
	output logic [11:0] range_end,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  window_size
);

	localparam int AW  = $clog2(MAX_FRAGMENTS);
	localparam int CW  = $clog2(MAX_FRAGMENTS + 1);
	localparam int WW  = ((CW > 13) ? CW : 13) + 1;
	localparam int RCW = $clog2(fgt_pkg::RESULT_CAP + 1);
	localparam int FW  = fgt_pkg::FIELD_W;

	fgt_pkg::state_t state_q, state_d;

	logic [6:0]     win_size_q;
	logic [CW-1:0]  win_start_q;
	logic [AW-1:0]  win_end_q;
	logic [CW-1:0]  total_q;
	logic           active_q;

	logic [11:0]    idx_q;
	logic [CW-1:0]  clr_idx_q;

	logic [CW-1:0]  scan_idx_q;
	logic [AW-1:0]  scan_last_q;
	logic           issue_more_q;
	logic           vld_s1;
	logic [AW-1:0]  idx_s1;
	logic           open_q;
	logic [AW-1:0]  run_start_q;
	logic [RCW-1:0] run_cnt_q;

	logic               pend_valid_q;
	fgt_pkg::kind_t     pend_kind_q;
	logic [FW-1:0]      pend_start_q;
	logic [FW-1:0]      pend_end_q;

	logic               out_valid_q;
	fgt_pkg::kind_t     out_kind_q;
	logic [FW-1:0]      out_start_q;
	logic [FW-1:0]      out_end_q;
	logic               out_last_q;

	logic map_mem [MAX_FRAGMENTS];
	logic rd_data_q;

	// Combinational control
	logic          accept;
	logic          out_free;
	fgt_pkg::op_t  op;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] tot_sat;
	logic [AW-1:0] start_we;
	logic [WW-1:0] tlast;
	logic [AW-1:0] scan_last_init;
	logic          scan_empty;
	logic          last_ent;
	logic          raw_rng;
	logic          rng_vld;
	logic [AW-1:0] rng_start;
	logic [AW-1:0] rng_end;
	logic          new_open;
	logic [AW-1:0] new_run_start;
	logic          stall;
	logic          scan_done;
	logic          push_mid;
	logic          push_fin;
	logic          clr_last;
	logic          frag_oor;
	logic          frag_new;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [WW-1:0] adv_end_sum;
	logic [AW-1:0] adv_end;
	logic [CW-1:0] adv_start;

	assign op       = fgt_pkg::op_t'(opcode);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Window arithmetic for start, status scan and advance.
	always_comb begin
		if (win_size_q == 7'd0) begin
			w_eff = WW'(1);
		end else if (WW'(win_size_q) > WW'(MAX_WINDOW)) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(win_size_q);
		end

		if (WW'(fragment_total) > WW'(MAX_FRAGMENTS)) begin
			tot_sat = WW'(MAX_FRAGMENTS);
		end else begin
			tot_sat = WW'(fragment_total);
		end

		if (tot_sat == '0) begin
			start_we = '0;
		end else if (w_eff < tot_sat) begin
			start_we = AW'(w_eff - WW'(1));
		end else begin
			start_we = AW'(tot_sat - WW'(1));
		end

		tlast = WW'(total_q) - WW'(1);
		if (WW'(win_end_q) < tlast) begin
			scan_last_init = win_end_q;
		end else begin
			scan_last_init = AW'(tlast);
		end
		scan_empty = (WW'(win_start_q) > WW'(win_end_q)) || (WW'(win_start_q) >= WW'(total_q));

		adv_end_sum = WW'(win_end_q) + w_eff;
		adv_end     = (adv_end_sum > tlast) ? AW'(tlast) : AW'(adv_end_sum);
		adv_start   = CW'(WW'(win_end_q) + WW'(1));
	end

	// Scan entry evaluation: at most one run closes per entry.
	always_comb begin
		last_ent      = (idx_s1 == scan_last_q);
		raw_rng       = 1'b0;
		rng_start     = run_start_q;
		rng_end       = idx_s1;
		new_open      = open_q;
		new_run_start = run_start_q;
		if (!rd_data_q) begin
			new_run_start = open_q ? run_start_q : idx_s1;
			new_open      = !last_ent;
			if (last_ent) begin
				raw_rng   = 1'b1;
				rng_start = new_run_start;
				rng_end   = idx_s1;
			end
		end else begin
			new_open = 1'b0;
			if (open_q) begin
				raw_rng = 1'b1;
				rng_end = idx_s1 - AW'(1);
			end
		end
		rng_vld = vld_s1 && raw_rng && (RCW'(fgt_pkg::RESULT_CAP) > run_cnt_q);
	end

	assign frag_oor = (WW'(idx_q) >= WW'(total_q));
	assign frag_new = !frag_oor && !rd_data_q;
	assign clr_last = (clr_idx_q + CW'(1) == total_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fgt_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == fgt_pkg::OP_START) begin
						state_d = (tot_sat == '0) ? fgt_pkg::ST_FLUSH : fgt_pkg::ST_CLEAR;
					end else if (op == fgt_pkg::OP_FRAGMENT && active_q) begin
						state_d = fgt_pkg::ST_FRAG;
					end else if (op == fgt_pkg::OP_STATUS && active_q) begin
						state_d = fgt_pkg::ST_SCAN;
					end else begin
						state_d = fgt_pkg::ST_FLUSH;
					end
				end
			end
			fgt_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = fgt_pkg::ST_FLUSH;
				end
			end
			fgt_pkg::ST_FRAG: begin
				state_d = fgt_pkg::ST_FLUSH;
			end
			fgt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = fgt_pkg::ST_FLUSH;
				end
			end
			fgt_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = fgt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fgt_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = 1'b0;
		stall     = 1'b0;
		scan_done = 1'b0;
		push_mid  = 1'b0;
		push_fin  = 1'b0;
		rd_addr   = AW'(idx_q);
		mem_we    = 1'b0;
		mem_waddr = AW'(idx_q);
		mem_wdata = 1'b1;
		case (state_q)
			fgt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = AW'(fragment_index);
			end
			fgt_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(clr_idx_q);
				mem_wdata = 1'b0;
			end
			fgt_pkg::ST_FRAG: begin
				mem_we = frag_new;
			end
			fgt_pkg::ST_SCAN: begin
				// A new run can only be parked once the older one has gone out.
				stall     = rng_vld && pend_valid_q && !out_free;
				scan_done = !issue_more_q && !vld_s1;
				push_mid  = rng_vld && pend_valid_q && out_free;
				rd_addr   = stall ? idx_s1 : AW'(scan_idx_q);
			end
			fgt_pkg::ST_FLUSH: begin
				push_fin = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// Received map: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fgt_pkg::ST_IDLE;
			win_size_q   <= fgt_pkg::WINDOW_SIZE_RESET;
			win_start_q  <= '0;
			win_end_q    <= '0;
			total_q      <= '0;
			active_q     <= 1'b0;
			issue_more_q <= 1'b0;
			vld_s1       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				win_size_q <= window_size;
			end

			if (accept) begin
				case (op)
					fgt_pkg::OP_START: begin
						total_q      <= CW'(tot_sat);
						active_q     <= 1'b1;
						win_start_q  <= '0;
						win_end_q    <= start_we;
						pend_valid_q <= 1'b1;
					end
					fgt_pkg::OP_STATUS: begin
						if (active_q) begin
							issue_more_q <= !scan_empty;
							vld_s1       <= 1'b0;
							pend_valid_q <= 1'b0;
						end else begin
							pend_valid_q <= 1'b1;
						end
					end
					default: begin
						pend_valid_q <= 1'b1;
					end
				endcase
			end

			if (state_q == fgt_pkg::ST_SCAN) begin
				if (!stall) begin
					vld_s1 <= issue_more_q;
					if (issue_more_q) begin
						issue_more_q <= (AW'(scan_idx_q) != scan_last_q);
					end
					if (rng_vld) begin
						pend_valid_q <= 1'b1;
					end
				end
				if (scan_done && !pend_valid_q) begin
					pend_valid_q <= 1'b1;
					if (WW'(win_start_q) >= WW'(total_q)) begin
						active_q <= 1'b0;
					end else begin
						win_start_q <= adv_start;
						win_end_q   <= adv_end;
					end
				end
			end

			if (push_fin) begin
				pend_valid_q <= 1'b0;
			end

			if (push_mid || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= fragment_index;
			clr_idx_q <= '0;
			case (op)
				fgt_pkg::OP_START: begin
					pend_kind_q  <= fgt_pkg::KIND_STARTED;
					pend_start_q <= '0;
					pend_end_q   <= FW'(start_we);
				end
				fgt_pkg::OP_STATUS: begin
					pend_kind_q  <= fgt_pkg::KIND_IDLE;
					pend_start_q <= '0;
					pend_end_q   <= '0;
					scan_idx_q   <= win_start_q;
					scan_last_q  <= scan_last_init;
					open_q       <= 1'b0;
					run_cnt_q    <= '0;
				end
				default: begin
					pend_kind_q  <= fgt_pkg::KIND_IDLE;
					pend_start_q <= '0;
					pend_end_q   <= '0;
				end
			endcase
		end

		if (state_q == fgt_pkg::ST_CLEAR) begin
			clr_idx_q <= clr_idx_q + CW'(1);
		end

		if (state_q == fgt_pkg::ST_FRAG) begin
			pend_start_q <= idx_q;
			pend_end_q   <= idx_q;
			if (frag_oor) begin
				pend_kind_q <= fgt_pkg::KIND_OUT_OF_RANGE;
			end else if (rd_data_q) begin
				pend_kind_q <= fgt_pkg::KIND_DUPLICATE;
			end else begin
				pend_kind_q <= fgt_pkg::KIND_ACCEPTED;
			end
		end

		if (state_q == fgt_pkg::ST_SCAN) begin
			if (!stall) begin
				idx_s1     <= AW'(scan_idx_q);
				scan_idx_q <= scan_idx_q + CW'(1);
				if (vld_s1) begin
					open_q      <= new_open;
					run_start_q <= new_run_start;
				end
				if (rng_vld) begin
					pend_kind_q  <= fgt_pkg::KIND_MISSING;
					pend_start_q <= FW'(rng_start);
					pend_end_q   <= FW'(rng_end);
					run_cnt_q    <= run_cnt_q + RCW'(1);
				end
			end
			if (scan_done && !pend_valid_q) begin
				if (WW'(win_start_q) >= WW'(total_q)) begin
					pend_kind_q  <= fgt_pkg::KIND_COMPLETE;
					pend_start_q <= '0;
					pend_end_q   <= '0;
				end else begin
					pend_kind_q  <= fgt_pkg::KIND_ADVANCED;
					pend_start_q <= FW'(adv_start);
					pend_end_q   <= FW'(adv_end);
				end
			end
		end

		if (push_mid || push_fin) begin
			out_kind_q  <= pend_kind_q;
			out_start_q <= pend_start_q;
			out_end_q   <= pend_end_q;
			out_last_q  <= push_fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign range_start = out_start_q;
	assign range_end   = out_end_q;
	assign last        = out_last_q;

endmodule

// ===== rtl/core/fgt_checker.sv =====
`include "assert_macros.svh"

module fgt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic [11:0] fragment_index,
	input logic [12:0] fragment_total,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [11:0] range_start,
	input logic [11:0] range_end,
	input logic        last,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [6:0]  window_size
);

	// A result beat held back by the sink keeps its payload.
	`FGT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(range_start) && $stable(range_end) && $stable(last),
		"stalled result beat changed")

	// One item at a time: the input is closed in the cycle after a beat is taken.
	`FGT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready,
		"input taken again straight after a beat")

	// Only missing-range results can be followed by more results of the same item.
	`FGT_ASSERT_IMP(a_single_last, clk, arst_n,
		out_valid && (kind != fgt_pkg::KIND_MISSING), last,
		"non-range result without last")

	`FGT_ASSERT_IMP(a_range_order, clk, arst_n,
		out_valid && (kind == fgt_pkg::KIND_MISSING), range_start <= range_end,
		"missing range runs backwards")

	`FGT_ASSERT_IMP(a_zero_fields, clk, arst_n,
		out_valid && ((kind == fgt_pkg::KIND_IDLE) || (kind == fgt_pkg::KIND_COMPLETE)),
		(range_start == 12'd0) && (range_end == 12'd0),
		"idle or complete result with non-zero range")

endmodule

bind fragment_gap_tracker fgt_checker u_fgt_checker (.*);
